// ----- rtl/ntcb_pkg.sv -----
// ----------------------------------------------------------------------------
// ntcb_pkg
// Widths, constants and the ln segment table of the NTC beta converter.
// ----------------------------------------------------------------------------
package ntcb_pkg;

   localparam int ADC_BITS  = 10;
   localparam int REG_W     = 24;
   localparam int BETA_W    = 16;
   localparam int ST_W      = 2;
   localparam int CSR_IDX_W = 2;

   // half-LSB sample position and divider operands
   localparam int X_W      = ADC_BITS + 1;
   localparam int RD_W     = ADC_BITS + 1;
   localparam int RN_W     = REG_W + RD_W;
   localparam int RR_W     = RN_W + 1;
   localparam int RQ_W     = REG_W;
   localparam int RSTG     = RQ_W / 2;

   // ln unit
   localparam int NUM_W    = REG_W + X_W;
   localparam int NSTEP    = $clog2(NUM_W);
   localparam int NORM_STG = (NSTEP + 1) / 2;
   localparam int KLN_W    = NSTEP + 32;
   localparam int STEP_W   = 12;
   localparam int PROD_W   = STEP_W + 28;
   localparam int LN_W     = 22;
   localparam int L_W      = LN_W + 1;

   // temperature division
   localparam int SCALE_W  = 30;
   localparam int BS_W     = BETA_W + SCALE_W;
   localparam int D_W      = BS_W + 1;
   localparam int NN_W     = BS_W + 15;
   localparam int Q_W      = 64;
   localparam int T_W      = 17;
   localparam int TSTG     = T_W;

   // output formatting
   localparam int TC_W     = 18;
   localparam int TF_W     = 19;
   localparam int FV_W     = 20;
   localparam int FP_W     = 2 * FV_W;
   localparam int DIV5_S   = 22;

   localparam int SIDE_N   = NORM_STG + 4;
   localparam int PIPE_N   = NORM_STG + TSTG + 7;

   localparam logic [T_W-1:0]     TMAX    = 17'd100000;
   localparam logic [RQ_W-1:0]    RMAX    = '1;
   localparam logic [31:0]        LN2_Q32 = 32'd2977044472;
   localparam logic [SCALE_W-1:0] SCALE   = 30'd655360000;
   localparam logic [15:0]        T0      = 16'd29815;
   localparam logic [T_W-1:0]     K_OFS   = 17'd27315;
   localparam logic [T_W-1:0]     F_OFS   = 17'd45967;
   localparam logic [FV_W-1:0]    DIV5_M  = 20'd838861;

   localparam logic [REG_W-1:0]   PAIR_RST = 24'd10000;
   localparam logic [REG_W-1:0]   NOM_RST  = 24'd10000;
   localparam logic [BETA_W-1:0]  BETA_RST = 16'd3950;

   localparam logic MODE_PULLUP = 1'b0;
   localparam logic MODE_PULLDN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOM  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA = 2'd3;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
   localparam logic [ST_W-1:0] ST_OPEN  = 2'd2;

   // round(ln(1 + i/16) * 65536)
   function automatic logic [15:0] ln_seg(input logic [4:0] idx);
      logic [15:0] v;
      case (idx)
         5'd0:  v = 16'd0;
         5'd1:  v = 16'd3973;
         5'd2:  v = 16'd7719;
         5'd3:  v = 16'd11262;
         5'd4:  v = 16'd14624;
         5'd5:  v = 16'd17821;
         5'd6:  v = 16'd20870;
         5'd7:  v = 16'd23783;
         5'd8:  v = 16'd26573;
         5'd9:  v = 16'd29248;
         5'd10: v = 16'd31818;
         5'd11: v = 16'd34292;
         5'd12: v = 16'd36675;
         5'd13: v = 16'd38975;
         5'd14: v = 16'd41196;
         5'd15: v = 16'd43345;
         5'd16: v = 16'd45426;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/ntc_beta_temperature_convert_core.sv -----
// ----------------------------------------------------------------------------
// ntc_beta_temperature_convert_core
// NTC thermistor divider sample to resistance and beta-equation temperature.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   req      | req_valid/req_stall  | adc_sample
//   rsp      | rsp_valid/rsp_stall  | resistance, kelvin, celsius, fahrenheit,
//            |                      | accuracy, status
//   csr      | csr_valid/csr_ready  | csr_index, csr_data
//
// One sample per cycle unless rsp stalls; the 28 register stages include the
// 17-stage temperature divider, the 3-stage ln normalizer and the ln/beta
// stages around them. All stages advance together while the
// output register is empty or being taken; a stall holds every stage in place.
// Synchronous reset clears valid bits and restores the register defaults.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_convert_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ntcb_pkg::ADC_BITS-1:0]        req_adc_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ntcb_pkg::REG_W-1:0]           rsp_resistance_ohms,
   output logic [ntcb_pkg::T_W-1:0]             rsp_temp_kelvin,
   output logic signed [ntcb_pkg::TC_W-1:0]     rsp_temp_celsius,
   output logic signed [ntcb_pkg::TF_W-1:0]     rsp_temp_fahrenheit,
   output logic [ntcb_pkg::T_W-1:0]             rsp_accuracy_kelvin,
   output logic [ntcb_pkg::ST_W-1:0]            rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ntcb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ntcb_pkg::REG_W-1:0]           csr_data
);
   import ntcb_pkg::*;

   typedef struct packed {
      logic [NUM_W-1:0] v;
      logic [NSTEP-1:0] lz;
   } norm_type;

   typedef struct packed {
      logic [RR_W-1:0] rem;
      logic [RD_W-1:0] den;
      logic [RQ_W-1:0] quo;
      logic            sat;
   } rdiv_type;

   typedef struct packed {
      logic [ST_W-1:0] status;
      rdiv_type        r;
   } side_type;

   typedef struct packed {
      logic [Q_W-1:0] rem;
      logic [D_W-1:0] d;
      logic [T_W-1:0] quo;
      logic           sat;
   } tdiv_type;

   typedef struct packed {
      logic [ST_W-1:0] status;
      rdiv_type        r;
      tdiv_type [2:0]  t;
   } qst_type;

   typedef struct packed {
      logic [15:0]       base;
      logic [PROD_W-1:0] prod;
      logic [KLN_W-1:0]  kln;
   } lnp_type;

   // configuration
   logic                mode_ff;
   logic [REG_W-1:0]    pair_ff;
   logic [REG_W-1:0]    nom_ff;
   logic [BETA_W-1:0]   beta_ff;
   logic [BS_W-1:0]     bscale_ff;
   logic [NN_W-1:0]     nn_ff;
   logic [REG_W-1:0]    r25;
   logic [BETA_W-1:0]   b_eff;

   logic                adv;
   logic [PIPE_N-1:0]   vld_ff;

   logic [ADC_BITS-1:0] s0_a_ff;

   logic [ST_W-1:0]     s1_status_in, s1_status_ff;
   logic [NUM_W-1:0]    s1_op_in [0:5];
   logic [NUM_W-1:0]    s1_op_ff [0:5];
   logic [RN_W-1:0]     s1_rnum_in, s1_rnum_ff;
   logic [RD_W-1:0]     s1_rden_in, s1_rden_ff;

   norm_type            norm_in [0:NORM_STG-1][0:5];
   norm_type            norm_ff [0:NORM_STG-1][0:5];
   side_type            side_in [0:SIDE_N-1];
   side_type            side_ff [0:SIDE_N-1];

   lnp_type             lnp_in [0:5];
   lnp_type             lnp_ff [0:5];
   logic signed [L_W-1:0] l_in [0:2];
   logic signed [L_W-1:0] l_ff [0:2];
   logic [D_W-1:0]      d_in [0:2];
   logic [D_W-1:0]      d_ff [0:2];
   logic                dneg_in [0:2];
   logic                dneg_ff [0:2];
   logic [Q_W-1:0]      n_in [0:2];
   logic [Q_W-1:0]      n_ff [0:2];
   logic [D_W-1:0]      nd_ff [0:2];
   logic                nneg_ff [0:2];

   qst_type             q_in [0:TSTG-1];
   qst_type             q_ff [0:TSTG-1];

   logic [ST_W-1:0]     fin_status_ff;
   logic [RQ_W-1:0]     fin_r_in, fin_r_ff;
   logic [T_W-1:0]      fin_t_in [0:2];
   logic [T_W-1:0]      fin_t_ff [0:2];

   logic                rsp_valid_ff;
   logic [REG_W-1:0]    res_in, res_ff;
   logic [T_W-1:0]      tk_in, tk_ff;
   logic [TC_W-1:0]     tc_in, tc_ff;
   logic [TF_W-1:0]     tf_in, tf_ff;
   logic [T_W-1:0]      acc_in, acc_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PULLUP;
         pair_ff <= PAIR_RST;
         nom_ff  <= NOM_RST;
         beta_ff <= BETA_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE: mode_ff <= csr_data[0];
            CSR_PAIR: pair_ff <= csr_data;
            CSR_NOM:  nom_ff  <= csr_data;
            CSR_BETA: beta_ff <= csr_data[BETA_W-1:0];
            default: ;
         endcase
      end
   end

   assign r25   = (nom_ff == '0) ? REG_W'(1) : nom_ff;
   assign b_eff = (beta_ff == '0) ? BETA_W'(1) : beta_ff;

   // derived constants, registered in bscale_ff and then in nn_ff after a write
   always_ff @(posedge clock) begin
      bscale_ff <= BS_W'(b_eff) * BS_W'(SCALE);
      nn_ff     <= NN_W'(T0) * NN_W'(bscale_ff);
   end

   // ------------------------------------------------------ operand stage
   always_comb begin
      logic [X_W-1:0]  xm;
      logic [X_W-1:0]  xs;
      logic [X_W-1:0]  xc;
      logic [RD_W-1:0] a_ext;
      logic [RD_W-1:0] a_cmp;
      xm    = {s0_a_ff, 1'b0};
      a_ext = RD_W'(s0_a_ff);
      a_cmp = {1'b1, {ADC_BITS{1'b0}}} - a_ext;
      for (int i = 0; i < 3; i++) begin
         xs = xm + X_W'(i) - X_W'(1);
         xc = X_W'(0) - xs;
         if (mode_ff == MODE_PULLUP) begin
            s1_op_in[i]   = NUM_W'(pair_ff) * NUM_W'(xs);
            s1_op_in[i+3] = NUM_W'(r25) * NUM_W'(xc);
         end else begin
            s1_op_in[i]   = NUM_W'(pair_ff) * NUM_W'(xc);
            s1_op_in[i+3] = NUM_W'(r25) * NUM_W'(xs);
         end
      end
      if (mode_ff == MODE_PULLUP) begin
         s1_rnum_in = RN_W'(pair_ff) * RN_W'(a_ext);
         s1_rden_in = a_cmp;
      end else begin
         s1_rnum_in = RN_W'(pair_ff) * RN_W'(a_cmp);
         s1_rden_in = a_ext;
      end
      if (pair_ff == '0 || (s0_a_ff == '0 && mode_ff == MODE_PULLUP)) begin
         s1_status_in = ST_SHORT;
      end else if (s0_a_ff == '0) begin
         s1_status_in = ST_OPEN;
      end else begin
         s1_status_in = ST_OK;
      end
   end

   // ------------------------------------------------------ ln normalize
   always_comb begin
      norm_type cur;
      int       sh;
      for (int g = 0; g < NORM_STG; g++) begin
         for (int ln = 0; ln < 6; ln++) begin
            if (g == 0) begin
               cur.v  = s1_op_ff[ln];
               cur.lz = '0;
            end else begin
               cur = norm_ff[g-1][ln];
            end
            for (int t = 0; t < 2; t++) begin
               if (2 * g + t < NSTEP) begin
                  sh = 1 << (NSTEP - 1 - 2 * g - t);
                  if ((cur.v >> (NUM_W - sh)) == '0) begin
                     cur.v  = cur.v << sh;
                     cur.lz = cur.lz + NSTEP'(sh);
                  end
               end
            end
            norm_in[g][ln] = cur;
         end
      end
   end

   // side line: status and resistance divider operands
   always_comb begin
      side_in[0].status  = s1_status_ff;
      side_in[0].r.rem   = RR_W'(s1_rnum_ff) + RR_W'(s1_rden_ff >> 1);
      side_in[0].r.den   = s1_rden_ff;
      side_in[0].r.quo   = '0;
      side_in[0].r.sat   = 1'b0;
      for (int k = 1; k < SIDE_N; k++) begin
         side_in[k] = side_ff[k-1];
      end
   end

   // ------------------------------------------------------ ln table / terms
   always_comb begin
      logic [NUM_W-1:0]    nv;
      logic [NSTEP-1:0]    k;
      logic [NUM_W+30:0]   ext;
      logic [31:0]         f;
      logic [15:0]         lo;
      logic [15:0]         hi;
      for (int ln = 0; ln < 6; ln++) begin
         nv  = norm_ff[NORM_STG-1][ln].v;
         k   = NSTEP'(NUM_W - 1) - norm_ff[NORM_STG-1][ln].lz;
         ext = {nv[NUM_W-2:0], 32'd0};
         f   = ext[NUM_W+30 -: 32];
         lo  = ln_seg({1'b0, f[31:28]});
         hi  = ln_seg({1'b0, f[31:28]} + 5'd1);
         lnp_in[ln].base = lo;
         lnp_in[ln].prod = PROD_W'(STEP_W'(hi - lo)) * PROD_W'(f[27:0]);
         lnp_in[ln].kln  = KLN_W'(k) * KLN_W'(LN2_Q32);
      end
   end

   // ------------------------------------------------------ ln sum, ratio
   always_comb begin
      logic [KLN_W:0]  kr;
      logic [PROD_W:0] pr;
      logic [LN_W-1:0] lnv [0:5];
      for (int ln = 0; ln < 6; ln++) begin
         kr = (KLN_W+1)'(lnp_ff[ln].kln) + (KLN_W+1)'(32768);
         pr = (PROD_W+1)'(lnp_ff[ln].prod) + (PROD_W+1)'(134217728);
         lnv[ln] = LN_W'(kr >> 16) + LN_W'(lnp_ff[ln].base) + LN_W'(pr >> 28);
      end
      for (int i = 0; i < 3; i++) begin
         l_in[i] = $signed({1'b0, lnv[i]}) - $signed({1'b0, lnv[i+3]});
      end
   end

   // ------------------------------------------------------ denominator
   always_comb begin
      logic signed [D_W:0] dsum;
      for (int i = 0; i < 3; i++) begin
         dsum       = $signed({1'b0, bscale_ff}) + $signed(T0) * l_ff[i];
         dneg_in[i] = dsum[D_W] || (dsum == '0);
         d_in[i]    = dsum[D_W-1:0];
         n_in[i]    = Q_W'(nn_ff) + Q_W'(d_ff[i] >> 1);
      end
   end

   // ------------------------------------------------------ dividers
   always_comb begin
      qst_type         cur;
      logic [Q_W-1:0]  tsh;
      logic [RR_W-1:0] rsh;
      int              bit_i;
      for (int j = 0; j < TSTG; j++) begin
         if (j == 0) begin
            cur.status = side_ff[SIDE_N-1].status;
            cur.r      = side_ff[SIDE_N-1].r;
            for (int i = 0; i < 3; i++) begin
               cur.t[i].rem = n_ff[i];
               cur.t[i].d   = nd_ff[i];
               cur.t[i].quo = '0;
               cur.t[i].sat = nneg_ff[i];
               if (n_ff[i] >= (Q_W'(nd_ff[i]) << T_W)) begin
                  cur.t[i].sat = 1'b1;
               end
            end
            if (cur.r.rem >= (RR_W'(cur.r.den) << RQ_W)) begin
               cur.r.sat = 1'b1;
            end
         end else begin
            cur = q_ff[j-1];
         end
         for (int i = 0; i < 3; i++) begin
            tsh = Q_W'(cur.t[i].d) << (T_W - 1 - j);
            if (cur.t[i].rem >= tsh) begin
               cur.t[i].rem             = cur.t[i].rem - tsh;
               cur.t[i].quo[T_W-1-j]    = 1'b1;
            end
         end
         if (j < RSTG) begin
            for (int b = 0; b < 2; b++) begin
               bit_i = RQ_W - 1 - 2 * j - b;
               rsh   = RR_W'(cur.r.den) << bit_i;
               if (cur.r.rem >= rsh) begin
                  cur.r.rem        = cur.r.rem - rsh;
                  cur.r.quo[bit_i] = 1'b1;
               end
            end
         end
         q_in[j] = cur;
      end
   end

   // ------------------------------------------------------ saturation
   always_comb begin
      fin_r_in = q_ff[TSTG-1].r.sat ? RMAX : q_ff[TSTG-1].r.quo;
      for (int i = 0; i < 3; i++) begin
         if (q_ff[TSTG-1].t[i].sat || q_ff[TSTG-1].t[i].quo > TMAX) begin
            fin_t_in[i] = TMAX;
         end else begin
            fin_t_in[i] = q_ff[TSTG-1].t[i].quo;
         end
      end
   end

   // ------------------------------------------------------ output format
   always_comb begin
      logic [T_W-1:0]  du;
      logic [T_W-1:0]  dl;
      logic [FV_W-1:0] fv;
      logic [FP_W-1:0] fp;
      du = (fin_t_ff[2] > fin_t_ff[1]) ? fin_t_ff[2] - fin_t_ff[1]
                                        : fin_t_ff[1] - fin_t_ff[2];
      dl = (fin_t_ff[0] > fin_t_ff[1]) ? fin_t_ff[0] - fin_t_ff[1]
                                        : fin_t_ff[1] - fin_t_ff[0];
      fv = FV_W'(fin_t_ff[1]) * FV_W'(9) + FV_W'(2);
      fp = FP_W'(fv) * FP_W'(DIV5_M);
      if (fin_status_ff == ST_OK) begin
         res_in = fin_r_ff;
         tk_in  = fin_t_ff[1];
         tc_in  = TC_W'(fin_t_ff[1]) - TC_W'(K_OFS);
         tf_in  = TF_W'(fp >> DIV5_S) - TF_W'(F_OFS);
         acc_in = (du > dl) ? du : dl;
      end else begin
         res_in = '0;
         tk_in  = '0;
         tc_in  = '0;
         tf_in  = '0;
         acc_in = '0;
      end
   end

   // ------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PIPE_N-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_a_ff       <= req_adc_sample;
         s1_status_ff  <= s1_status_in;
         s1_op_ff      <= s1_op_in;
         s1_rnum_ff    <= s1_rnum_in;
         s1_rden_ff    <= s1_rden_in;
         norm_ff       <= norm_in;
         side_ff       <= side_in;
         lnp_ff        <= lnp_in;
         l_ff          <= l_in;
         d_ff          <= d_in;
         dneg_ff       <= dneg_in;
         n_ff          <= n_in;
         nd_ff         <= d_ff;
         nneg_ff       <= dneg_ff;
         q_ff          <= q_in;
         fin_status_ff <= q_ff[TSTG-1].status;
         fin_r_ff      <= fin_r_in;
         fin_t_ff      <= fin_t_in;
         res_ff        <= res_in;
         tk_ff         <= tk_in;
         tc_ff         <= tc_in;
         tf_ff         <= tf_in;
         acc_ff        <= acc_in;
         rsp_status    <= fin_status_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_resistance_ohms = res_ff;
   assign rsp_temp_kelvin     = tk_ff;
   assign rsp_temp_celsius    = $signed(tc_ff);
   assign rsp_temp_fahrenheit = $signed(tf_ff);
   assign rsp_accuracy_kelvin = acc_ff;

endmodule

// ----- bench/ntc_beta_temperature_convert_core_tb.sv -----
// ----------------------------------------------------------------------------
// ntc_beta_temperature_convert_core_tb
// Self-checking bench for the NTC beta converter. Samples are sent under
// random sender gaps and receiver stalls across several register settings.
// Each accepted sample is converted by a fixed-point predictor and queued;
// each rsp transfer is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_convert_core_tb;
   import ntcb_pkg::*;

   typedef struct {
      logic [REG_W-1:0]        ohms;
      logic [T_W-1:0]          kelvin;
      logic signed [TC_W-1:0]  celsius;
      logic signed [TF_W-1:0]  fahrenheit;
      logic [T_W-1:0]          accuracy;
      logic [ST_W-1:0]         status;
   } conv_t;

   localparam longint LN_SEG_TAB [17] = '{0, 3973, 7719, 11262, 14624, 17821,
      20870, 23783, 26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ADC_BITS-1:0]   req_adc_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [REG_W-1:0]      rsp_resistance_ohms;
   logic [T_W-1:0]        rsp_temp_kelvin;
   logic signed [TC_W-1:0] rsp_temp_celsius;
   logic signed [TF_W-1:0] rsp_temp_fahrenheit;
   logic [T_W-1:0]        rsp_accuracy_kelvin;
   logic [ST_W-1:0]       rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [REG_W-1:0]      csr_data = '0;

   logic                  mode_m = MODE_PULLUP;
   logic [REG_W-1:0]      pair_m = PAIR_RST;
   logic [REG_W-1:0]      nom_m  = NOM_RST;
   logic [BETA_W-1:0]     beta_m = BETA_RST;

   conv_t pending_q [$];
   int    errors = 0;
   bit    idle_en = 1'b1;
   int    hold_cycles = 0;

   ntc_beta_temperature_convert_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint ln_fix(longint unsigned n);
      int k;
      longint unsigned mant, f, rem;
      int idx;
      longint base, stp;
      k = 0;
      if (n == 0) n = 1;
      while (k < 63 && (n >> (k + 1)) != 0) k++;
      mant = n << (63 - k);
      f    = (mant >> 31) & 64'hFFFF_FFFF;
      idx  = int'((f >> 28) & 15);
      rem  = f & 64'h0FFF_FFFF;
      base = LN_SEG_TAB[idx];
      stp  = LN_SEG_TAB[idx + 1] - LN_SEG_TAB[idx];
      base += longint'((longint'(stp) * rem + (64'd1 << 27)) >> 28);
      return longint'((longint'(k) * 64'd2977044472 + (64'd1 << 15)) >> 16) + base;
   endfunction

   function automatic longint temp_at_pos(longint unsigned x);
      longint unsigned fs2, r25, num, den;
      longint b, l, d, nn, q;
      fs2 = 64'd1 << (ADC_BITS + 1);
      r25 = (nom_m != 0) ? nom_m : 1;
      b   = (beta_m != 0) ? beta_m : 1;
      if (mode_m == MODE_PULLUP) begin
         num = pair_m * x;
         den = r25 * (fs2 - x);
      end else begin
         num = pair_m * (fs2 - x);
         den = r25 * x;
      end
      l = ln_fix(num) - ln_fix(den);
      d = b * 655360000 + 29815 * l;
      if (d <= 0) return 100000;
      nn = 29815 * b * 655360000;
      q  = (nn + d / 2) / d;
      return (q > 100000) ? 100000 : q;
   endfunction

   function automatic conv_t convert_sample(logic [ADC_BITS-1:0] a);
      conv_t c;
      longint unsigned fs, num, den, r;
      longint t, tu, tl, du, dl;
      fs = 64'd1 << ADC_BITS;
      c = '{default: '0};
      if (pair_m == 0 || (a == 0 && mode_m == MODE_PULLUP)) begin
         c.status = ST_SHORT;
         return c;
      end
      if (a == 0) begin
         c.status = ST_OPEN;
         return c;
      end
      if (mode_m == MODE_PULLUP) begin
         num = pair_m * a;
         den = fs - a;
      end else begin
         num = pair_m * (fs - a);
         den = a;
      end
      r = (num + den / 2) / den;
      if (r > 24'hFFFFFF) r = 24'hFFFFFF;
      t  = temp_at_pos(2 * a);
      tu = temp_at_pos(2 * a + 1);
      tl = temp_at_pos(2 * a - 1);
      du = (tu > t) ? tu - t : t - tu;
      dl = (tl > t) ? tl - t : t - tl;
      c.ohms       = r[REG_W-1:0];
      c.kelvin     = t[T_W-1:0];
      c.celsius    = TC_W'(t - 27315);
      c.fahrenheit = TF_W'((t * 9 + 2) / 5 - 45967);
      c.accuracy   = T_W'((du > dl) ? du : dl);
      c.status     = ST_OK;
      return c;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_q.push_back(convert_sample(req_adc_sample));
   end

   always @(posedge clock) begin
      conv_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            $error("rsp transfer with no expected result");
            errors++;
         end else begin
            e = pending_q.pop_front();
            if (rsp_resistance_ohms !== e.ohms) begin
               $error("resistance_ohms exp %0d got %0d", e.ohms, rsp_resistance_ohms);
               errors++;
            end
            if (rsp_temp_kelvin !== e.kelvin) begin
               $error("temp_kelvin exp %0d got %0d", e.kelvin, rsp_temp_kelvin);
               errors++;
            end
            if (rsp_temp_celsius !== e.celsius) begin
               $error("temp_celsius exp %0d got %0d", e.celsius, rsp_temp_celsius);
               errors++;
            end
            if (rsp_temp_fahrenheit !== e.fahrenheit) begin
               $error("temp_fahrenheit exp %0d got %0d", e.fahrenheit,
                      rsp_temp_fahrenheit);
               errors++;
            end
            if (rsp_accuracy_kelvin !== e.accuracy) begin
               $error("accuracy_kelvin exp %0d got %0d", e.accuracy, rsp_accuracy_kelvin);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= idle_en && ($urandom_range(99) < 32);
      end
   end

   // call at a falling edge; returns at a falling edge with valid still high
   task automatic send_sample(logic [ADC_BITS-1:0] a);
      if (idle_en && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < 32) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= a;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE: mode_m = val[0];
         CSR_PAIR: pair_m = val;
         CSR_NOM:  nom_m  = val;
         CSR_BETA: beta_m = val[BETA_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(logic m, logic [REG_W-1:0] p, logic [REG_W-1:0] n,
                           logic [REG_W-1:0] b);
      write_reg(CSR_MODE, REG_W'({$urandom, m}));
      write_reg(CSR_PAIR, p);
      write_reg(CSR_NOM, n);
      write_reg(CSR_BETA, b);
   endtask

   function automatic logic [ADC_BITS-1:0] rand_sample();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return ADC_BITS'($urandom_range(3));
         default: return ADC_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [REG_W-1:0] rand_ohms();
      case ($urandom_range(5))
         0: return REG_W'($urandom_range(1, 20));
         1: return '1;
         2: return REG_W'($urandom_range(100, 100000));
         default: return REG_W'($urandom);
      endcase
   endfunction

   task automatic test_directed;
      logic [ADC_BITS-1:0] pts [7] = '{0, 1, 2, 511, 512, 1022, 1023};
      foreach (pts[i]) send_sample(pts[i]);
      drain();
      set_regs(MODE_PULLDN, PAIR_RST, NOM_RST, BETA_RST);
      foreach (pts[i]) send_sample(pts[i]);
      drain();
      set_regs(MODE_PULLUP, 24'd0, NOM_RST, BETA_RST);   // short via pair
      send_sample(10'd5);
      send_sample(10'd0);
      drain();
      set_regs(MODE_PULLUP, 24'd1, 24'hFFFFFF, 24'd1);   // tiny R, hot overflow
      send_sample(10'd1);
      send_sample(10'd1023);
      drain();
      set_regs(MODE_PULLDN, 24'hFFFFFF, 24'd0, 24'd0);   // zero nominal/beta
      send_sample(10'd1);
      send_sample(10'd512);
      drain();
      set_regs(MODE_PULLUP, 24'hFFFFFF, 24'd1, 24'hFFFFFF);
      send_sample(10'd1);
      send_sample(10'd1023);
      drain();
   endtask

   task automatic test_random_phases;
      for (int ph = 0; ph < 8; ph++) begin
         set_regs(1'($urandom_range(1)), rand_ohms(), rand_ohms(), REG_W'($urandom));
         for (int i = 0; i < 80; i++) begin
            send_sample(rand_sample());
            if (i == 40 && ph % 2 == 0) begin
               drain();
               @(negedge clock);
            end
         end
         drain();
      end
   endtask

   task automatic test_backpressure;
      set_regs(1'($urandom_range(1)), PAIR_RST, NOM_RST, BETA_RST);
      hold_cycles = 150;
      for (int i = 0; i < 80; i++) send_sample(rand_sample());
      drain();
   endtask

   task automatic test_no_idle;
      idle_en = 1'b0;
      set_regs(MODE_PULLUP, rand_ohms(), rand_ohms(), 24'd3435);
      for (int i = 0; i < 100; i++) send_sample(rand_sample());
      drain();
      idle_en = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_phases();
      test_backpressure();
      test_no_idle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
